[rtl/msp_pkg.sv]
// shared widths, reset values, register indexes and unit status type
// for the motor speed pid block; no dependencies
package msp_pkg;

  // field widths
  localparam int TARGET_W   = 16;
  localparam int ENC_W      = 32;
  localparam int SPEED_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int CLAMP_W    = 17;
  localparam int ERR_W      = 17;
  localparam int INTEG_W    = 18;
  localparam int DRIVE_W    = 9;
  localparam int PWM_W      = 8;
  localparam int FRAC_W     = 8;
  localparam int DRIVE_MAX  = 255;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd5;

  localparam logic [GAIN_W-1:0]         RST_PROP_GAIN   = 16'd1024;
  localparam logic [GAIN_W-1:0]         RST_INTEG_GAIN  = 16'd38;
  localparam logic [GAIN_W-1:0]         RST_DERIV_GAIN  = 16'd768;
  localparam logic signed [CLAMP_W-1:0] RST_INTEG_UPPER = 17'sd65280;
  localparam logic signed [CLAMP_W-1:0] RST_INTEG_LOWER = -17'sd65280;
  localparam logic [GAIN_W-1:0]         RST_SPEED_SCALE = 16'd2887;

  // shared serial multiplier: signed multiplicand, unsigned 16-bit multiplier,
  // two multiplier bits retired per step
  localparam int MC_W      = 33;
  localparam int MUL_B_W   = GAIN_W;
  localparam int MUL_STEPS = MUL_B_W / 2;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int PROD_W    = MC_W + MUL_B_W;

  // averaging window default
  localparam int AVG_TAPS_DEF = 5;

  // status of a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

[rtl/msp_mul.sv]
// shift-and-add multiplier, two multiplier bits per cycle
// depends on msp_pkg
module msp_mul (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [msp_pkg::MC_W-1:0]    mcand_i,
  input  logic        [msp_pkg::MUL_B_W-1:0] mplier_i,
  output logic signed [msp_pkg::PROD_W-1:0]  prod_o,
  output msp_pkg::unit_stat_t                stat_o
);

  logic signed [msp_pkg::PROD_W-1:0]  mc_q, acc_q, acc_d;
  logic        [msp_pkg::MUL_B_W-1:0] mp_q;
  logic        [msp_pkg::MUL_CNT_W-1:0] cnt_q;
  logic                               busy_q, done_q;

  // partial products of the current digit
  always_comb begin
    acc_d = acc_q;
    if (mp_q[0]) acc_d = acc_d + mc_q;
    if (mp_q[1]) acc_d = acc_d + (mc_q <<< 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q   <= '0;
      mp_q   <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      // done pulses once, after the last digit
      done_q <= busy_q && !start_i &&
                (cnt_q == msp_pkg::MUL_CNT_W'(msp_pkg::MUL_STEPS - 1));
      if (start_i) begin
        mc_q   <= msp_pkg::PROD_W'(mcand_i);
        mp_q   <= mplier_i;
        acc_q  <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        acc_q <= acc_d;
        mc_q  <= mc_q <<< 2;
        mp_q  <= mp_q >> 2;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == msp_pkg::MUL_CNT_W'(msp_pkg::MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign prod_o      = acc_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[rtl/msp_avg.sv]
// speed history and moving average: serial sum over the taps, then
// restoring division by the tap count one quotient bit per cycle; depends on msp_pkg
module msp_avg #(
  parameter int AVG_TAPS = msp_pkg::AVG_TAPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [msp_pkg::SPEED_W-1:0] speed_i,
  output logic signed [msp_pkg::SPEED_W-1:0] filt_o,
  output msp_pkg::unit_stat_t                stat_o
);

  localparam int HIST_LEN = AVG_TAPS - 1;
  localparam int SUM_W    = msp_pkg::SPEED_W + $clog2(AVG_TAPS);
  localparam int IDX_W    = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
  localparam int REM_W    = $clog2(AVG_TAPS) + 1;
  localparam int DCNT_W   = $clog2(SUM_W);
  localparam logic [REM_W-1:0] DIVISOR = REM_W'(AVG_TAPS);

  typedef enum logic [1:0] {A_IDLE, A_SUM, A_DIV} avg_state_e;

  avg_state_e                         state_q;
  logic signed [msp_pkg::SPEED_W-1:0] hist_q [HIST_LEN];
  logic signed [msp_pkg::SPEED_W-1:0] speed_q, filt_q;
  logic signed [SUM_W-1:0]            sum_q, sum_d;
  logic        [SUM_W-1:0]            mag_q, mag_d, quo_q, quo_d;
  logic        [REM_W-1:0]            rem_q, rem_d, trial;
  logic        [IDX_W-1:0]            idx_q;
  logic        [DCNT_W-1:0]           dcnt_q;
  logic                               neg_q, done_q, ge;
  logic        [msp_pkg::SPEED_W-1:0] quo_lo;

  // running sum and its magnitude
  always_comb begin
    sum_d = sum_q + SUM_W'(hist_q[idx_q]);
    mag_d = sum_d[SUM_W-1] ? SUM_W'(-sum_d) : SUM_W'(sum_d);
  end

  // one restoring division step
  always_comb begin
    trial  = {rem_q[REM_W-2:0], mag_q[SUM_W-1]};
    ge     = (trial >= DIVISOR);
    rem_d  = ge ? (trial - DIVISOR) : trial;
    quo_d  = {quo_q[SUM_W-2:0], ge};
    quo_lo = quo_d[msp_pkg::SPEED_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      for (int i = 0; i < HIST_LEN; i++) hist_q[i] <= '0;
      speed_q <= '0;
      filt_q  <= '0;
      sum_q   <= '0;
      mag_q   <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      idx_q   <= '0;
      dcnt_q  <= '0;
      neg_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      // done pulses once, with the last quotient bit
      done_q <= (state_q == A_DIV) && (dcnt_q == DCNT_W'(SUM_W - 1));
      case (state_q)
        A_IDLE: begin
          if (start_i) begin
            speed_q <= speed_i;
            sum_q   <= SUM_W'(speed_i);
            idx_q   <= '0;
            state_q <= A_SUM;
          end
        end
        A_SUM: begin
          sum_q <= sum_d;
          idx_q <= idx_q + 1'b1;
          if (idx_q == IDX_W'(HIST_LEN - 1)) begin
            mag_q   <= mag_d;
            neg_q   <= sum_d[SUM_W-1];
            rem_q   <= '0;
            quo_q   <= '0;
            dcnt_q  <= '0;
            state_q <= A_DIV;
          end
        end
        A_DIV: begin
          rem_q  <= rem_d;
          quo_q  <= quo_d;
          mag_q  <= mag_q << 1;
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
            filt_q    <= neg_q ? -$signed(quo_lo) : $signed(quo_lo);
            hist_q[0] <= speed_q;
            for (int i = 1; i < HIST_LEN; i++) hist_q[i] <= hist_q[i-1];
            state_q <= A_IDLE;
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign filt_o      = filt_q;
  assign stat_o.busy = (state_q != A_IDLE);
  assign stat_o.done = done_q;

endmodule

[rtl/motor_speed_pid.sv]
// motor speed pid: one word in, one word out; the shared two-bit-per-cycle multiplier
// (four products) and the serial average set how long a word takes; one word at a time,
// the next accepted while a result waits on the output
// reset: gains and clamps to their defaults, position, history, integral and error to zero
module motor_speed_pid #(
  parameter int AVG_TAPS = msp_pkg::AVG_TAPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  // input words
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [47:0]                        s_axis_tdata,  // target_speed, encoder_count
  // result words
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [39:0]                        m_axis_tdata   // drive_value, pwm_duty,
                                                            // dir_pin_a, dir_pin_b,
                                                            // filtered_speed
);

  localparam int MV_W     = 36;
  localparam int ISUM_W   = 35;
  localparam int DIFF_W   = msp_pkg::ERR_W + 1;
  localparam int MVG_W    = 17;
  localparam int DADJ_W   = MVG_W + 1;
  localparam logic signed [MV_W-1:0] MV_LIM =
    MV_W'(msp_pkg::DRIVE_MAX << msp_pkg::FRAC_W);

  typedef enum logic [2:0] {
    S_IDLE, S_SPEED, S_AVG, S_INT, S_PROP, S_DER, S_OUT
  } state_e;

  // configuration registers
  logic        [msp_pkg::GAIN_W-1:0]  kp_q, ki_q, kd_q, scale_q;
  logic signed [msp_pkg::CLAMP_W-1:0] upper_q, lower_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= msp_pkg::RST_PROP_GAIN;
      ki_q    <= msp_pkg::RST_INTEG_GAIN;
      kd_q    <= msp_pkg::RST_DERIV_GAIN;
      upper_q <= msp_pkg::RST_INTEG_UPPER;
      lower_q <= msp_pkg::RST_INTEG_LOWER;
      scale_q <= msp_pkg::RST_SPEED_SCALE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msp_pkg::REG_PROP_GAIN:   kp_q    <= cfg_wdata_i[msp_pkg::GAIN_W-1:0];
        msp_pkg::REG_INTEG_GAIN:  ki_q    <= cfg_wdata_i[msp_pkg::GAIN_W-1:0];
        msp_pkg::REG_DERIV_GAIN:  kd_q    <= cfg_wdata_i[msp_pkg::GAIN_W-1:0];
        msp_pkg::REG_INTEG_UPPER: upper_q <= $signed(cfg_wdata_i);
        msp_pkg::REG_INTEG_LOWER: lower_q <= $signed(cfg_wdata_i);
        msp_pkg::REG_SPEED_SCALE: scale_q <= cfg_wdata_i[msp_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  state_e                              state_q;
  logic signed [msp_pkg::TARGET_W-1:0] tgt_q;
  logic        [msp_pkg::ENC_W-1:0]    prev_pos_q;
  logic signed [msp_pkg::INTEG_W-1:0]  integ_q;
  logic signed [msp_pkg::ERR_W-1:0]    err_q, perr_q, err_c;
  logic signed [MV_W-1:0]              mv_q;
  logic signed [msp_pkg::MC_W-1:0]     mc_q;
  logic        [msp_pkg::MUL_B_W-1:0]  mp_q;
  logic                                mul_start_q, avg_start_q;
  logic                                mul_start_d, avg_start_d;
  logic signed [msp_pkg::SPEED_W-1:0]  avg_speed_q;

  logic                                out_valid_q, out_valid_d, pin_a_q, pin_b_q;
  logic signed [msp_pkg::DRIVE_W-1:0]  drive_q;
  logic        [msp_pkg::PWM_W-1:0]    pwm_q;
  logic signed [msp_pkg::SPEED_W-1:0]  filt_out_q;

  logic signed [msp_pkg::PROD_W-1:0]   mul_prod;
  msp_pkg::unit_stat_t                 mul_stat, avg_stat;
  logic signed [msp_pkg::SPEED_W-1:0]  avg_filt;

  logic signed [msp_pkg::TARGET_W-1:0] in_target;
  logic        [msp_pkg::ENC_W-1:0]    in_enc, delta;

  msp_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .mcand_i  (mc_q),
    .mplier_i (mp_q),
    .prod_o   (mul_prod),
    .stat_o   (mul_stat)
  );

  msp_avg #(.AVG_TAPS(AVG_TAPS)) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (avg_start_q),
    .speed_i (avg_speed_q),
    .filt_o  (avg_filt),
    .stat_o  (avg_stat)
  );

  // input unpacking and position change
  assign in_target = $signed(s_axis_tdata[15:0]);
  assign in_enc    = s_axis_tdata[47:16];
  assign delta     = in_enc - prev_pos_q;

  // speed from the scaled position change, truncated toward zero and saturated
  logic signed [msp_pkg::PROD_W-1:0]  sp_adj, sp_full;
  logic signed [msp_pkg::SPEED_W-1:0] speed_c;

  always_comb begin
    sp_adj  = mul_prod + (mul_prod[msp_pkg::PROD_W-1] ?
                          msp_pkg::PROD_W'(255) : msp_pkg::PROD_W'(0));
    sp_full = sp_adj >>> msp_pkg::FRAC_W;
    if (sp_full > msp_pkg::PROD_W'(32767))       speed_c = 16'sh7fff;
    else if (sp_full < -msp_pkg::PROD_W'(32768)) speed_c = 16'sh8000;
    else                                         speed_c = sp_full[msp_pkg::SPEED_W-1:0];
  end

  // error against the filtered speed
  assign err_c = msp_pkg::ERR_W'(tgt_q) - msp_pkg::ERR_W'(avg_filt);

  // integral update with clamps, upper test first
  logic signed [ISUM_W-1:0]           isum;
  logic signed [msp_pkg::INTEG_W-1:0] integ_c;

  always_comb begin
    isum = ISUM_W'(integ_q) + ISUM_W'(mul_prod);
    if (isum > ISUM_W'(upper_q))      integ_c = msp_pkg::INTEG_W'(upper_q);
    else if (isum < ISUM_W'(lower_q)) integ_c = msp_pkg::INTEG_W'(lower_q);
    else                              integ_c = isum[msp_pkg::INTEG_W-1:0];
  end

  // derivative operand
  logic signed [DIFF_W-1:0] diff_c;
  assign diff_c = DIFF_W'(perr_q) - DIFF_W'(err_q);

  // sign gating, limit and truncation to whole drive units
  logic                               tgt_pos, tgt_neg, tgt_zero;
  logic signed [MVG_W-1:0]            mvg;
  logic signed [DADJ_W-1:0]           dadj;
  logic signed [msp_pkg::DRIVE_W-1:0] drive_c;

  always_comb begin
    tgt_zero = (tgt_q == '0);
    tgt_neg  = tgt_q[msp_pkg::TARGET_W-1];
    tgt_pos  = !tgt_neg && !tgt_zero;
    if ((tgt_pos && mv_q < 0) || (tgt_neg && mv_q > 0)) mvg = '0;
    else if (tgt_pos && mv_q > MV_LIM)                  mvg = MVG_W'(MV_LIM);
    else if (tgt_neg && mv_q < -MV_LIM)                 mvg = MVG_W'(-MV_LIM);
    else if (tgt_zero)                                  mvg = '0;
    else                                                mvg = mv_q[MVG_W-1:0];
    dadj    = DADJ_W'(mvg) + (mvg[MVG_W-1] ? DADJ_W'(255) : DADJ_W'(0));
    drive_c = msp_pkg::DRIVE_W'(dadj >>> msp_pkg::FRAC_W);
  end

  // unit start pulses and output valid
  always_comb begin
    mul_start_d = 1'b0;
    avg_start_d = 1'b0;
    case (state_q)
      S_IDLE:         mul_start_d = s_axis_tvalid;
      S_SPEED:        avg_start_d = mul_stat.done;
      S_AVG:          mul_start_d = avg_stat.done;
      S_INT, S_PROP:  mul_start_d = mul_stat.done;
      default: ;
    endcase
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) out_valid_d = 1'b0;
    if ((state_q == S_OUT) && (!out_valid_q || m_axis_tready)) out_valid_d = 1'b1;
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= '0;
      prev_pos_q  <= '0;
      integ_q     <= '0;
      err_q       <= '0;
      perr_q      <= '0;
      mv_q        <= '0;
      mc_q        <= '0;
      mp_q        <= '0;
      mul_start_q <= 1'b0;
      avg_start_q <= 1'b0;
      avg_speed_q <= '0;
      out_valid_q <= 1'b0;
      drive_q     <= '0;
      pwm_q       <= '0;
      pin_a_q     <= 1'b0;
      pin_b_q     <= 1'b0;
      filt_out_q  <= '0;
    end else begin
      mul_start_q <= mul_start_d;
      avg_start_q <= avg_start_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            tgt_q       <= in_target;
            prev_pos_q  <= in_enc;
            mc_q        <= msp_pkg::MC_W'($signed(delta));
            mp_q        <= scale_q;
            state_q     <= S_SPEED;
          end
        end
        S_SPEED: begin
          if (mul_stat.done) begin
            avg_speed_q <= speed_c;
            state_q     <= S_AVG;
          end
        end
        S_AVG: begin
          if (avg_stat.done) begin
            err_q       <= err_c;
            mc_q        <= msp_pkg::MC_W'(err_c);
            mp_q        <= ki_q;
            state_q     <= S_INT;
          end
        end
        S_INT: begin
          if (mul_stat.done) begin
            integ_q     <= integ_c;
            mc_q        <= msp_pkg::MC_W'(err_q);
            mp_q        <= kp_q;
            state_q     <= S_PROP;
          end
        end
        S_PROP: begin
          if (mul_stat.done) begin
            mv_q        <= MV_W'(mul_prod) + MV_W'(integ_q);
            mc_q        <= msp_pkg::MC_W'(diff_c);
            mp_q        <= kd_q;
            state_q     <= S_DER;
          end
        end
        S_DER: begin
          if (mul_stat.done) begin
            mv_q    <= mv_q + MV_W'(mul_prod);
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            drive_q     <= drive_c;
            pwm_q       <= drive_c[msp_pkg::DRIVE_W-1] ?
                           msp_pkg::PWM_W'(-drive_c) : msp_pkg::PWM_W'(drive_c);
            pin_a_q     <= !drive_c[msp_pkg::DRIVE_W-1];
            pin_b_q     <= drive_c[msp_pkg::DRIVE_W-1] || (drive_c == '0);
            filt_out_q  <= avg_filt;
            perr_q      <= err_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, filt_out_q, pin_b_q, pin_a_q, pwm_q, drive_q};

  // checks on the sequencing
  a_mul_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_units_idle_at_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT) |-> (!mul_stat.busy && !avg_stat.busy))
    else $error("unit still busy when result formed");

  a_brake_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((pin_a_q && pin_b_q) == (pwm_q == '0)))
    else $error("direction pins disagree with duty");

  a_accept_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> mul_start_q)
    else $error("accepted word did not start speed product");

endmodule

[tb/motor_speed_pid_chk.sv]
// checker for the motor speed pid block: follows register writes, predicts each
// result word from the accepted input words and compares it field by field
// depends on msp_pkg for widths, register indexes and reset values
module motor_speed_pid_chk #(
  parameter int AVG_TAPS = msp_pkg::AVG_TAPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               s_valid_i,
  input  logic                               s_ready_i,
  input  logic [47:0]                        s_data_i,   // target_speed, encoder_count
  input  logic                               m_valid_i,
  input  logic                               m_ready_i,
  input  logic [39:0]                        m_data_i,   // drive_value, pwm_duty,
                                                         // dir_pin_a, dir_pin_b,
                                                         // filtered_speed
  output int                                 mismatch_count_o,
  output int                                 words_due_o
);

  typedef struct {
    logic signed [msp_pkg::DRIVE_W-1:0] drive;
    logic [msp_pkg::PWM_W-1:0]          duty;
    logic                               pin_a;
    logic                               pin_b;
    logic signed [msp_pkg::SPEED_W-1:0] filt;
  } drive_word_t;

  // register copies
  logic [msp_pkg::GAIN_W-1:0]  kp, ki, kd, rpm_scale;
  logic [msp_pkg::CLAMP_W-1:0] integ_hi, integ_lo;

  // loop state
  logic [msp_pkg::ENC_W-1:0]          last_pos;
  logic signed [msp_pkg::SPEED_W-1:0] speed_hist [AVG_TAPS-1];
  longint                             integ_acc;
  longint                             last_err;

  drive_word_t drive_due_q [$];
  int          mismatches = 0;
  int          due_words  = 0;

  assign mismatch_count_o = mismatches;
  assign words_due_o      = due_words;

  // one control tick: measured speed, running average, pid, sign gating
  function automatic drive_word_t step_speed_loop(
      input logic signed [msp_pkg::TARGET_W-1:0] target,
      input logic [msp_pkg::ENC_W-1:0] pos);
    logic [msp_pkg::ENC_W-1:0] moved;
    longint delta, rpm, total, filt, err, hi, lo, mv, drv;
    drive_word_t w;
    moved = pos - last_pos;
    delta = longint'($signed(moved));
    rpm = (delta * longint'(rpm_scale)) / 256;
    // saturate to the 16-bit speed range
    if (rpm > 32767) rpm = 32767;
    else if (rpm < -32768) rpm = -32768;
    total = rpm;
    for (int k = 0; k < AVG_TAPS - 1; k++) total += speed_hist[k];
    filt = total / AVG_TAPS;
    err = longint'(target) - filt;
    // integral with clamps, upper test first
    hi = longint'($signed(integ_hi));
    lo = longint'($signed(integ_lo));
    integ_acc += err * longint'(ki);
    if (integ_acc > hi) integ_acc = hi;
    else if (integ_acc < lo) integ_acc = lo;
    mv = err * longint'(kp) + integ_acc + longint'(kd) * (last_err - err);
    // gate by setpoint sign and limit
    if ((target > 0 && mv < 0) || (target < 0 && mv > 0)) mv = 0;
    else if (target > 0 && mv > msp_pkg::DRIVE_MAX * 256) mv = msp_pkg::DRIVE_MAX * 256;
    else if (target < 0 && mv < -msp_pkg::DRIVE_MAX * 256) mv = -msp_pkg::DRIVE_MAX * 256;
    else if (target == 0) mv = 0;
    drv = mv / 256;
    if (drv > msp_pkg::DRIVE_MAX) drv = msp_pkg::DRIVE_MAX;
    if (drv < -msp_pkg::DRIVE_MAX) drv = -msp_pkg::DRIVE_MAX;
    w.drive = msp_pkg::DRIVE_W'(drv);
    w.duty  = msp_pkg::PWM_W'(drv < 0 ? -drv : drv);
    w.pin_a = (drv >= 0);
    w.pin_b = (drv <= 0);
    w.filt  = msp_pkg::SPEED_W'(filt);
    for (int k = AVG_TAPS - 2; k > 0; k--) speed_hist[k] = speed_hist[k-1];
    speed_hist[0] = msp_pkg::SPEED_W'(rpm);
    last_err = err;
    last_pos = pos;
    return w;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // register writes, prediction on accepted input words, comparison on result words
  always @(posedge clk_i or negedge rst_ni) begin
    drive_word_t want;
    if (!rst_ni) begin
      kp        = msp_pkg::RST_PROP_GAIN;
      ki        = msp_pkg::RST_INTEG_GAIN;
      kd        = msp_pkg::RST_DERIV_GAIN;
      integ_hi  = msp_pkg::RST_INTEG_UPPER;
      integ_lo  = msp_pkg::RST_INTEG_LOWER;
      rpm_scale = msp_pkg::RST_SPEED_SCALE;
      last_pos  = '0;
      foreach (speed_hist[k]) speed_hist[k] = '0;
      integ_acc = 0;
      last_err  = 0;
      drive_due_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          msp_pkg::REG_PROP_GAIN:   kp        = cfg_wdata_i[msp_pkg::GAIN_W-1:0];
          msp_pkg::REG_INTEG_GAIN:  ki        = cfg_wdata_i[msp_pkg::GAIN_W-1:0];
          msp_pkg::REG_DERIV_GAIN:  kd        = cfg_wdata_i[msp_pkg::GAIN_W-1:0];
          msp_pkg::REG_INTEG_UPPER: integ_hi  = cfg_wdata_i[msp_pkg::CLAMP_W-1:0];
          msp_pkg::REG_INTEG_LOWER: integ_lo  = cfg_wdata_i[msp_pkg::CLAMP_W-1:0];
          msp_pkg::REG_SPEED_SCALE: rpm_scale = cfg_wdata_i[msp_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i)
        drive_due_q.push_back(step_speed_loop($signed(s_data_i[15:0]), s_data_i[47:16]));
      if (m_valid_i && m_ready_i) begin
        if (drive_due_q.size() == 0) begin
          $error("result word 0x%h arrived with nothing expected", m_data_i);
          mismatches++;
        end else begin
          want = drive_due_q.pop_front();
          check_field("drive_value", longint'(want.drive), longint'($signed(m_data_i[8:0])));
          check_field("pwm_duty", longint'(want.duty), longint'(m_data_i[16:9]));
          check_field("dir_pin_a", longint'(want.pin_a), longint'(m_data_i[17]));
          check_field("dir_pin_b", longint'(want.pin_b), longint'(m_data_i[18]));
          check_field("filtered_speed", longint'(want.filt),
                      longint'($signed(m_data_i[34:19])));
          check_field("padding", 0, longint'(m_data_i[39:35]));
        end
      end
    end
    due_words = drive_due_q.size();
  end

endmodule

[tb/motor_speed_pid_tb.sv]
// testbench top for the motor speed pid block: clock, reset, register settings,
// directed and random input words, receiver stalls and the verdict
// depends on msp_pkg, motor_speed_pid and motor_speed_pid_chk
module motor_speed_pid_tb;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_WORDS  = 200;
  localparam int N_SETTINGS  = 8;
  localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [msp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [msp_pkg::CFG_DATA_W-1:0] cfg_wdata;
  logic                           s_valid;
  logic                           s_ready;
  logic [47:0]                    s_data;
  logic                           m_valid;
  logic                           m_ready;
  logic [39:0]                    m_data;

  int mismatches;
  int words_due;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int rx_hold        = 0;
  int quiet_cycles   = 0;
  int words_sent     = 0;
  int settings_done  = 0;

  // random walk of the encoder
  logic [msp_pkg::ENC_W-1:0]           enc_pos = '0;
  logic signed [msp_pkg::TARGET_W-1:0] run_target = '0;
  int                                  run_step = 0;
  int                                  run_left = 0;

  motor_speed_pid u_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  motor_speed_pid_chk u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .s_valid_i        (s_valid),
    .s_ready_i        (s_ready),
    .s_data_i         (s_data),
    .m_valid_i        (m_valid),
    .m_ready_i        (m_ready),
    .m_data_i         (m_data),
    .mismatch_count_o (mismatches),
    .words_due_o      (words_due)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    m_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        m_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end else begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog on cycles in which no word moves
  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no word moved for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // offer one word after random idle cycles; valid stays high across back-to-back words
  task automatic send_word(input logic [msp_pkg::TARGET_W-1:0] target,
                           input logic [msp_pkg::ENC_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {pos, target};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    words_sent++;
  endtask

  // stop offering and wait for every expected result word
  task automatic wait_drained;
    s_valid <= 1'b0;
    @(posedge clk);
    while (words_due != 0) @(posedge clk);
  endtask

  task automatic put_reg(input logic [msp_pkg::CFG_IDX_W-1:0] idx,
                         input logic [msp_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // write every register; the spare bit above 16-bit gains is random
  task automatic load_settings(input logic [msp_pkg::GAIN_W-1:0] p,
                               input logic [msp_pkg::GAIN_W-1:0] i,
                               input logic [msp_pkg::GAIN_W-1:0] d,
                               input logic [msp_pkg::CLAMP_W-1:0] up,
                               input logic [msp_pkg::CLAMP_W-1:0] lo,
                               input logic [msp_pkg::GAIN_W-1:0] sc);
    put_reg(REG_SPARE_A, msp_pkg::CFG_DATA_W'($urandom));
    put_reg(msp_pkg::REG_PROP_GAIN, {1'($urandom_range(1)), p});
    put_reg(msp_pkg::REG_INTEG_GAIN, {1'($urandom_range(1)), i});
    put_reg(msp_pkg::REG_DERIV_GAIN, {1'($urandom_range(1)), d});
    put_reg(msp_pkg::REG_INTEG_UPPER, up);
    put_reg(msp_pkg::REG_INTEG_LOWER, lo);
    put_reg(msp_pkg::REG_SPEED_SCALE, {1'($urandom_range(1)), sc});
    put_reg(REG_SPARE_B, msp_pkg::CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  // mostly steady runs of setpoint and speed, some words of pure noise
  task automatic send_random;
    int v;
    if ($urandom_range(99) < 12) begin
      enc_pos = msp_pkg::ENC_W'($urandom);
      send_word(msp_pkg::TARGET_W'($urandom), enc_pos);
    end else begin
      if (run_left == 0) begin
        run_left = $urandom_range(40, 4);
        case ($urandom_range(3))
          0: run_target = '0;
          1, 2: begin
            v = $urandom_range(6000) - 3000;
            run_target = msp_pkg::TARGET_W'(v);
          end
          default: run_target = msp_pkg::TARGET_W'($urandom);
        endcase
        if ($urandom_range(9) == 0) run_step = $urandom_range(80000) - 40000;
        else run_step = $urandom_range(600) - 300;
      end
      run_left--;
      v = run_step + int'($urandom_range(8)) - 4;
      enc_pos = enc_pos + msp_pkg::ENC_W'(v);
      send_word(run_target, enc_pos);
    end
  endtask

  function automatic logic [msp_pkg::CLAMP_W-1:0] rand_clamp;
    return msp_pkg::CLAMP_W'($urandom_range(130560) - 65280);
  endfunction

  // stimulus and verdict
  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      wait_drained;
      case (ph)
        0: load_settings(msp_pkg::RST_PROP_GAIN, msp_pkg::RST_INTEG_GAIN,
                         msp_pkg::RST_DERIV_GAIN, msp_pkg::RST_INTEG_UPPER,
                         msp_pkg::RST_INTEG_LOWER, msp_pkg::RST_SPEED_SCALE);
        1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 17'sd65280, -17'sd65280, 16'hFFFF);
        2: load_settings('0, '0, '0, '0, '0, '0);
        // crossed clamps
        3: load_settings(msp_pkg::RST_PROP_GAIN, msp_pkg::RST_INTEG_GAIN,
                         msp_pkg::RST_DERIV_GAIN, -17'sd5000, 17'sd5000,
                         msp_pkg::RST_SPEED_SCALE);
        // tiny gains so that drives fall under one unit
        4: load_settings(16'd1, 16'd0, 16'd0, 17'sd256, -17'sd256, 16'd256);
        5: load_settings(msp_pkg::GAIN_W'($urandom), msp_pkg::GAIN_W'($urandom),
                         msp_pkg::GAIN_W'($urandom), rand_clamp(), rand_clamp(),
                         msp_pkg::GAIN_W'($urandom));
        6: load_settings(msp_pkg::GAIN_W'($urandom_range(4096)),
                         msp_pkg::GAIN_W'($urandom_range(256)),
                         msp_pkg::GAIN_W'($urandom_range(4096)), -17'sd65280, 17'sd65280,
                         msp_pkg::GAIN_W'($urandom_range(8192)));
        default: load_settings(msp_pkg::GAIN_W'($urandom_range(2048)),
                               msp_pkg::GAIN_W'($urandom_range(128)),
                               msp_pkg::GAIN_W'($urandom_range(2048)),
                               17'sd65280, -17'sd65280,
                               msp_pkg::GAIN_W'($urandom_range(512)));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase

      if (ph == 0) begin
        // field extremes, speed saturation, position wrap
        send_word(16'sd0, 32'd0);
        send_word(16'h7FFF, 32'd0);
        send_word(16'h8000, 32'd0);
        send_word(16'sd1000, 32'd100);
        send_word(16'sd1000, 32'd10100);
        send_word(-16'sd1000, -32'sd9900);
        send_word(16'sd0, 32'h7FFF_FFFF);
        send_word(16'sd500, 32'h8000_0000);
        send_word(16'sd500, 32'h7FFF_FF00);
        send_word(16'h7FFF, 32'hFFFF_FFFF);
        send_word(16'h8000, 32'h0000_0000);
        // at rest with a zero setpoint
        repeat (5) send_word(16'sd0, 32'd0);
        // spinning against a small setpoint of either sign
        send_word(16'sd100, 32'd3000);
        send_word(16'sd100, 32'd6000);
        send_word(16'sd100, 32'd9000);
        send_word(-16'sd100, 32'd6000);
        send_word(-16'sd100, 32'd3000);
        send_word(-16'sd100, 32'd0);
        enc_pos = '0;
        // receiver holds off while words keep coming, so the input stalls
        rx_hold = HOLD_CYCLES;
      end
      if (ph == 4) begin
        // settle the average, then drives under one unit and just over
        repeat (5) send_word(16'sd0, enc_pos);
        send_word(16'sd100, enc_pos);
        send_word(-16'sd77, enc_pos);
        send_word(16'sd255, enc_pos);
        send_word(16'sd300, enc_pos);
        send_word(-16'sd300, enc_pos);
      end
      repeat (RAND_WORDS) send_random;
    end

    wait_drained;
    repeat (100) @(posedge clk);
    $display("run sent %0d words under %0d register settings, incl. crossed clamps",
             words_sent, settings_done);
    $display("flow control: free, sender gaps, receiver stalls, both, one long hold-off");
    if (mismatches == 0 && words_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
